// ===== sv/peq_pkg.sv =====
// Shared types and constants for the priority event queue with free pool.
package peq_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int NUM_LEVELS_DEF = 2;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int LEVEL_W  = 1;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_PUT   = 2'd2,
        MODE_GET   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DROP  = 2'd2
    } t_status;

endpackage

// ===== sv/peq_if.sv =====
// Valid/ready channel interfaces for operation requests and results.
interface peq_in_if;
    import peq_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [LEVEL_W-1:0] priority_req;

    modport source (output valid, output mode, output slot, output priority_req, input ready);
    modport sink   (input valid, input mode, input slot, input priority_req, output ready);
endinterface

interface peq_out_if;
    import peq_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot_out;
    logic [LEVEL_W-1:0]  level_out;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output slot_out, output level_out, output status, input ready);
    modport sink   (input valid, input slot_out, input level_out, input status, output ready);
endinterface

// ===== sv/priority_event_queue_with_free_pool_top.sv =====
// Slot pool manager with a free list and priority FIFOs kept as linked lists.
//
// Each beat on i_cmd is one operation: alloc, free, put or get. Each operation
// produces exactly one result beat on o_rsp carrying the slot, the level and
// a status code, in the order the operations were accepted.
// A request beat is captured in an input register. Once the output register
// is empty or being drained, the operation is executed against the link table
// and pointer registers and the result is written to the output register.
// One operation is executed per cycle, so while the receiver takes its results
// the block sustains one beat per cycle; the single link table read and the
// level priority select form the path between the two registers.
// When the receiver stalls, the result is held in the output register and
// one more request is held in the input register; after that i_cmd.ready
// drops until the result beat is taken.
// Reset links every slot onto the free list in index order, empties all
// priority FIFOs, clears the queued count and drops any held beats.
module priority_event_queue_with_free_pool_top #(
    parameter int NUM_SLOTS  = peq_pkg::NUM_SLOTS_DEF,
    parameter int NUM_LEVELS = peq_pkg::NUM_LEVELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    peq_in_if.sink     i_cmd,
    peq_out_if.source  o_rsp
);
    import peq_pkg::*;

    localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W   = (SLOT_W > LINK_W) ? SLOT_W : LINK_W;
    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int LCMP_W  = (LEVEL_W > LVL_W) ? LEVEL_W : LVL_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

    logic [LINK_W-1:0] r_link [NUM_SLOTS];
    logic [LINK_W-1:0] r_free_head;
    logic [LINK_W-1:0] r_head [NUM_LEVELS];
    logic [LINK_W-1:0] r_tail [NUM_LEVELS];
    logic [LINK_W-1:0] r_count;

    logic               r_in_vld;
    t_mode              r_mode;
    logic [SLOT_W-1:0]  r_slot;
    logic [LEVEL_W-1:0] r_prio;

    logic                r_out_vld;
    logic [SLOT_W-1:0]   r_slot_out;
    logic [LEVEL_W-1:0]  r_level_out;
    t_status             r_status;

    logic                fire;
    logic [CMP_W-1:0]    slot_cmp;
    logic                slot_ok;
    logic [IDX_W-1:0]    slot_idx;
    logic [LINK_W-1:0]   slot_link;
    logic [LCMP_W-1:0]   lvl_cmp;
    logic [LVL_W-1:0]    put_lvl;
    logic                free_ok;
    logic                found;
    logic [LVL_W-1:0]    get_lvl;
    logic [LINK_W-1:0]   get_head;
    logic [IDX_W-1:0]    rd_idx;
    logic [LINK_W-1:0]   rd_link;
    logic [LINK_W-1:0]   get_next;
    logic                tail_ok;
    logic                not_full;
    logic [SLOT_W-1:0]   n_slot_out;
    logic [LEVEL_W-1:0]  n_level_out;
    t_status             n_status;

    assign fire        = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_cmd.ready = !r_in_vld || fire;

    assign slot_cmp  = CMP_W'(r_slot);
    assign slot_ok   = slot_cmp < CMP_W'(NUM_SLOTS);
    assign slot_idx  = IDX_W'(slot_cmp);
    assign slot_link = LINK_W'(slot_cmp);
    assign lvl_cmp   = LCMP_W'(r_prio);
    assign put_lvl   = (lvl_cmp >= LCMP_W'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1)
                                                            : LVL_W'(lvl_cmp);
    assign free_ok   = r_free_head < NULL_LINK;
    assign tail_ok   = r_tail[put_lvl] < NULL_LINK;
    assign not_full  = r_count < NULL_LINK;

    always_comb begin
        found    = 1'b0;
        get_lvl  = '0;
        get_head = NULL_LINK;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_head[i] < NULL_LINK) begin
                found    = 1'b1;
                get_lvl  = LVL_W'(i);
                get_head = r_head[i];
            end
        end
    end

    assign rd_idx   = (r_mode == MODE_ALLOC) ? r_free_head[IDX_W-1:0] : get_head[IDX_W-1:0];
    assign rd_link  = r_link[rd_idx];
    assign get_next = (rd_link < NULL_LINK) ? rd_link : NULL_LINK;

    always_comb begin
        n_slot_out  = '0;
        n_level_out = '0;
        n_status    = ST_OK;
        unique case (r_mode)
            MODE_ALLOC: begin
                if (free_ok) begin
                    n_slot_out = SLOT_W'(r_free_head);
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            MODE_FREE: begin
                n_status = ST_OK;
            end
            MODE_PUT: begin
                if (slot_ok && !not_full) begin
                    n_status = ST_DROP;
                end
            end
            MODE_GET: begin
                if (found) begin
                    n_slot_out  = SLOT_W'(get_head);
                    n_level_out = LEVEL_W'(get_lvl);
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_mode <= t_mode'(i_cmd.mode);
            r_slot <= i_cmd.slot;
            r_prio <= i_cmd.priority_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_slot_out  <= n_slot_out;
            r_level_out <= n_level_out;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_link[i] <= LINK_W'(i + 1);
            end
            r_free_head <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= NULL_LINK;
                r_tail[i] <= NULL_LINK;
            end
            r_count <= '0;
        end else if (fire) begin
            unique case (r_mode)
                MODE_ALLOC: begin
                    if (free_ok) begin
                        r_free_head <= rd_link;
                    end
                end
                MODE_FREE: begin
                    if (slot_ok) begin
                        r_link[slot_idx] <= r_free_head;
                        r_free_head      <= slot_link;
                    end
                end
                MODE_PUT: begin
                    if (slot_ok) begin
                        if (not_full) begin
                            r_count          <= r_count + 1'b1;
                            r_link[slot_idx] <= NULL_LINK;
                            if (tail_ok) begin
                                r_link[r_tail[put_lvl][IDX_W-1:0]] <= slot_link;
                            end else begin
                                r_head[put_lvl] <= slot_link;
                            end
                            r_tail[put_lvl] <= slot_link;
                        end else begin
                            r_link[slot_idx] <= r_free_head;
                            r_free_head      <= slot_link;
                        end
                    end
                end
                MODE_GET: begin
                    if (found) begin
                        r_head[get_lvl] <= get_next;
                        if (get_next == NULL_LINK) begin
                            r_tail[get_lvl] <= NULL_LINK;
                        end
                        if (r_count != '0) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.slot_out  = r_slot_out;
    assign o_rsp.level_out = r_level_out;
    assign o_rsp.status    = r_status;

endmodule
